>>> design/ale_pkg.sv
// Shared constants, codes and controller/datapath interface types of the array list engine.
package ale_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 7;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int TOTAL_W  = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_INS_AT   = 3'd1,
    CMD_INS_SORT = 3'd2,
    CMD_LIN      = 3'd3,
    CMD_BIN      = 3'd4
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ABSENT = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_J,
    POS_MID
  } pos_sel_t;

  typedef enum logic [1:0] {
    RD_J,
    RD_JM1,
    RD_MID
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_WR,
    S_SORT,
    S_SORT_CHK,
    S_LIN,
    S_LIN_CHK,
    S_BIN,
    S_BIN_CHK,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    logic      wr_key;
    logic      j_dec;
    logic      j_inc;
    logic      bin_lo;
    logic      bin_hi;
    logic      clear;
    logic      cnt_inc;
    logic      fin;
    status_e_t fin_status;
    pos_sel_t  fin_pos;
    logic      emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             idx_over;
    logic             j_gt_idx;
    logic             j_zero;
    logic             j_lt_count;
    logic             bin_open;
    logic             rd_eq;
    logic             key_lt_rd;
    logic             rd_lt_key;
    logic             out_busy;
  } dp_stat_t;

endpackage

>>> design/ale_dp.sv
// Datapath of the array list engine: entry memory, indexes, count and result registers.
module ale_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ale_pkg::CMD_W-1:0]   in_command,
  input  logic signed [ale_pkg::KEY_W-1:0] in_key,
  input  logic [ale_pkg::IDX_W-1:0]   in_slot_index,
  input  ale_pkg::dp_cmd_t            cmd,
  output ale_pkg::dp_stat_t           stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ale_pkg::STATUS_W-1:0] out_status,
  output logic [ale_pkg::POS_W-1:0]   out_position,
  output logic [ale_pkg::TOTAL_W-1:0] out_total
);

  logic [ale_pkg::CMD_W-1:0]        cmd_r;
  logic signed [ale_pkg::KEY_W-1:0] key_r;
  logic [ale_pkg::IDX_W-1:0]        idx_r;
  logic [ale_pkg::CNT_W-1:0]        count;
  logic [ale_pkg::CNT_W-1:0]        count_next;
  logic [ale_pkg::CNT_W-1:0]        j;
  logic signed [ale_pkg::CNT_W:0]   left;
  logic signed [ale_pkg::CNT_W:0]   right;
  logic signed [ale_pkg::CNT_W+1:0] mid_sum;
  logic [ale_pkg::ADDR_W-1:0]       mid;
  logic [ale_pkg::ADDR_W-1:0]       mid_calc;
  logic [ale_pkg::ADDR_W-1:0]       rd_addr;
  logic signed [ale_pkg::KEY_W-1:0] rdata;
  logic signed [ale_pkg::KEY_W-1:0] mem [ale_pkg::CAPACITY];
  logic [ale_pkg::STATUS_W-1:0]     res_status;
  logic [ale_pkg::POS_W-1:0]        res_pos;
  logic [ale_pkg::TOTAL_W-1:0]      res_total;

  // left and right are both in range whenever a midpoint is probed
  assign mid_sum  = (ale_pkg::CNT_W+2)'(left) + (ale_pkg::CNT_W+2)'(right);
  assign mid_calc = mid_sum[ale_pkg::ADDR_W:1];

  always_comb begin
    case (cmd.rd_sel)
      ale_pkg::RD_J:   rd_addr = j[ale_pkg::ADDR_W-1:0];
      ale_pkg::RD_JM1: rd_addr = ale_pkg::ADDR_W'(j - 1'b1);
      ale_pkg::RD_MID: rd_addr = mid_calc;
      default:         rd_addr = j[ale_pkg::ADDR_W-1:0];
    endcase
  end

  always_comb begin
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.cnt_inc) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  // entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[j[ale_pkg::ADDR_W-1:0]] <= cmd.wr_key ? key_r : rdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      key_r <= in_key;
      idx_r <= in_slot_index;
      j     <= (in_command == ale_pkg::CMD_LIN) ? '0 : count;
      left  <= '0;
      right <= $signed({1'b0, count}) - (ale_pkg::CNT_W+1)'(1);
    end else begin
      if (cmd.j_dec) begin
        j <= j - 1'b1;
      end else if (cmd.j_inc) begin
        j <= j + 1'b1;
      end
      if (cmd.bin_lo) begin
        left <= (ale_pkg::CNT_W+1)'(mid) + (ale_pkg::CNT_W+1)'(1);
      end
      if (cmd.bin_hi) begin
        right <= (ale_pkg::CNT_W+1)'(mid) - (ale_pkg::CNT_W+1)'(1);
      end
    end
    if (cmd.rd_en && cmd.rd_sel == ale_pkg::RD_MID) begin
      mid <= mid_calc;
    end
    if (cmd.fin) begin
      res_status <= cmd.fin_status;
      case (cmd.fin_pos)
        ale_pkg::POS_J:   res_pos <= ale_pkg::POS_W'(j);
        ale_pkg::POS_MID: res_pos <= ale_pkg::POS_W'(mid);
        default:          res_pos <= '0;
      endcase
      res_total <= ale_pkg::TOTAL_W'(count_next);
    end
    if (cmd.emit) begin
      out_status   <= res_status;
      out_position <= res_pos;
      out_total    <= res_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.full       = count >= ale_pkg::CNT_W'(ale_pkg::CAPACITY);
    stat.idx_over   = 32'(idx_r) > 32'(count);
    stat.j_gt_idx   = 32'(j) > 32'(idx_r);
    stat.j_zero     = (j == '0);
    stat.j_lt_count = j < count;
    stat.bin_open   = left <= right;
    stat.rd_eq      = rdata == key_r;
    stat.key_lt_rd  = key_r < rdata;
    stat.rd_lt_key  = rdata < key_r;
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

>>> design/ale_ctrl.sv
// Controller state machine of the array list engine.
module ale_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ale_pkg::dp_stat_t stat,
  output ale_pkg::dp_cmd_t  cmd
);

  ale_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ale_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ale_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ale_pkg::S_DECIDE;
        end
      end
      ale_pkg::S_DECIDE: begin
        case (stat.cmd)
          ale_pkg::CMD_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.fin        = 1'b1;
            cmd.fin_status = ale_pkg::ST_OK;
            cmd.fin_pos    = ale_pkg::POS_ZERO;
            state_next     = ale_pkg::S_DONE;
          end
          ale_pkg::CMD_INS_AT: begin
            if (stat.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ale_pkg::ST_FULL;
              state_next     = ale_pkg::S_DONE;
            end else if (stat.idx_over) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ale_pkg::ST_RANGE;
              state_next     = ale_pkg::S_DONE;
            end else begin
              state_next = ale_pkg::S_SHIFT;
            end
          end
          ale_pkg::CMD_INS_SORT: begin
            if (stat.full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ale_pkg::ST_FULL;
              state_next     = ale_pkg::S_DONE;
            end else begin
              state_next = ale_pkg::S_SORT;
            end
          end
          ale_pkg::CMD_LIN: state_next = ale_pkg::S_LIN;
          ale_pkg::CMD_BIN: state_next = ale_pkg::S_BIN;
          default: begin
            cmd.fin        = 1'b1;
            cmd.fin_status = ale_pkg::ST_OK;
            cmd.fin_pos    = ale_pkg::POS_ZERO;
            state_next     = ale_pkg::S_DONE;
          end
        endcase
      end
      ale_pkg::S_SHIFT: begin
        if (stat.j_gt_idx) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_JM1;
          state_next = ale_pkg::S_SHIFT_WR;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_key     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_OK;
          cmd.fin_pos    = ale_pkg::POS_J;
          state_next     = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.j_dec  = 1'b1;
        state_next = ale_pkg::S_SHIFT;
      end
      ale_pkg::S_SORT: begin
        if (!stat.j_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_JM1;
          state_next = ale_pkg::S_SORT_CHK;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_key     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_OK;
          cmd.fin_pos    = ale_pkg::POS_J;
          state_next     = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_SORT_CHK: begin
        if (stat.key_lt_rd) begin
          cmd.wr_en  = 1'b1;
          cmd.j_dec  = 1'b1;
          state_next = ale_pkg::S_SORT;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_key     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_OK;
          cmd.fin_pos    = ale_pkg::POS_J;
          state_next     = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_LIN: begin
        if (stat.j_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_J;
          state_next = ale_pkg::S_LIN_CHK;
        end else begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_ABSENT;
          state_next     = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_LIN_CHK: begin
        if (stat.rd_eq) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_OK;
          cmd.fin_pos    = ale_pkg::POS_J;
          state_next     = ale_pkg::S_DONE;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = ale_pkg::S_LIN;
        end
      end
      ale_pkg::S_BIN: begin
        if (stat.bin_open) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ale_pkg::RD_MID;
          state_next = ale_pkg::S_BIN_CHK;
        end else begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_ABSENT;
          state_next     = ale_pkg::S_DONE;
        end
      end
      ale_pkg::S_BIN_CHK: begin
        if (stat.rd_eq) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ale_pkg::ST_OK;
          cmd.fin_pos    = ale_pkg::POS_MID;
          state_next     = ale_pkg::S_DONE;
        end else begin
          if (stat.rd_lt_key) begin
            cmd.bin_lo = 1'b1;
          end else begin
            cmd.bin_hi = 1'b1;
          end
          state_next = ale_pkg::S_BIN;
        end
      end
      ale_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ale_pkg::S_IDLE;
        end
      end
      default: state_next = ale_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/array_list_engine.sv
// Top level of the array list engine: stream ports, controller and datapath.
//
// Bounded list of up to 64 signed 32-bit keys held in a single-port-write,
// registered-read entry memory. Each input item carries one command (clear,
// insert at index, sorted insert, linear search, binary search) and yields
// exactly one result item with a status, a position and the entry count
// after the command. Items are handled one at a time. Insert at index and
// sorted insert move one entry at a time (read the entry below, then write
// it one slot up). Linear search probes one entry at a time, binary search
// one midpoint at a time. This stepping is set by the single read port and
// its registered output. A finished result sits in an output register: the
// engine goes back to accepting the next item as soon as that register is
// free or is being drained. The entry memory has no reset; only entries
// below the count are ever read.
module array_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] command, [34:3] key, [41:35] slot_index, [47:42] zero
  input  logic [ale_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [7:2] position, [14:8] element_total, [15] zero
  output logic [ale_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int KEY_LO = ale_pkg::CMD_W;
  localparam int IDX_LO = KEY_LO + ale_pkg::KEY_W;
  localparam int IN_USED = IDX_LO + ale_pkg::IDX_W;
  localparam int OUT_USED = ale_pkg::STATUS_W + ale_pkg::POS_W + ale_pkg::TOTAL_W;

  ale_pkg::dp_cmd_t  cmd;
  ale_pkg::dp_stat_t stat;

  logic [ale_pkg::CMD_W-1:0]        in_command;
  logic signed [ale_pkg::KEY_W-1:0] in_key;
  logic [ale_pkg::IDX_W-1:0]        in_slot_index;
  logic [ale_pkg::STATUS_W-1:0]     out_status;
  logic [ale_pkg::POS_W-1:0]        out_position;
  logic [ale_pkg::TOTAL_W-1:0]      out_total;

  // unpack input item; padding bits above IN_USED are ignored
  assign in_command    = s_tdata[ale_pkg::CMD_W-1:0];
  assign in_key        = $signed(s_tdata[IDX_LO-1:KEY_LO]);
  assign in_slot_index = s_tdata[IN_USED-1:IDX_LO];

  assign m_tdata = {(ale_pkg::OUT_TDATA_W - OUT_USED)'(0), out_total, out_position, out_status};

  ale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ale_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_command    (in_command),
    .in_key        (in_key),
    .in_slot_index (in_slot_index),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (out_status),
    .out_position  (out_position),
    .out_total     (out_total)
  );

`ifndef NO_ASSERTIONS
  // reported count never goes beyond the list capacity
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(out_total) <= ale_pkg::CAPACITY))
    else $error("element_total above capacity");

  // every failing status reports position zero
  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != ale_pkg::ST_OK) |-> (out_position == '0))
    else $error("nonzero position on failed command");

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous item in work");

  // a result is only pushed into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_tvalid && !m_tready))
    else $error("result overwrote pending output");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking stream testbench for array_list_engine: list predictor, directed and random commands.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;

  // Codes five to seven are left unused by the block and must act as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 140;
  localparam int PHASE_ITEMS   = 185;
  localparam int MAX_PRINTS    = 100;

  typedef struct packed {
    status_e_t          status;
    logic [POS_W-1:0]   position;
    logic [TOTAL_W-1:0] total;
  } list_result_t;

  // Mirror of the key list plus the results owed by the block, oldest first.
  class list_scoreboard;
    logic signed [KEY_W-1:0] keys [CAPACITY];
    int                      held;
    int                      peak_held;
    list_result_t            owed_q [$];
    int unsigned             mismatches;
    int unsigned             results_seen;
    int unsigned             status_tally [4];

    function new();
      held = 0;
      peak_held = 0;
      mismatches = 0;
      results_seen = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted command to the mirror and queue the result it owes.
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
                               logic [IDX_W-1:0] slot);
      list_result_t r;
      int           j;
      int           lo;
      int           hi;
      int           mid;
      bit           found;
      r.status   = ST_OK;
      r.position = '0;
      found      = 1'b0;
      case (cmd)
        CMD_CLEAR: begin
          held = 0;
        end
        CMD_INS_AT: begin
          // a full list wins over a bad index
          if (held >= CAPACITY) r.status = ST_FULL;
          else if (slot > held) r.status = ST_RANGE;
          else begin
            for (j = held; j > slot; j--) keys[j] = keys[j-1];
            keys[slot] = key;
            held++;
            r.position = slot[POS_W-1:0];
          end
        end
        CMD_INS_SORT: begin
          if (held >= CAPACITY) r.status = ST_FULL;
          else begin
            j = held;
            while (j > 0 && key < keys[j-1]) begin
              keys[j] = keys[j-1];
              j--;
            end
            keys[j] = key;
            held++;
            r.position = j[POS_W-1:0];
          end
        end
        CMD_LIN: begin
          j = 0;
          while (j < held && !found) begin
            if (keys[j] == key) found = 1'b1;
            else j++;
          end
          if (found) r.position = j[POS_W-1:0];
          else r.status = ST_ABSENT;
        end
        CMD_BIN: begin
          // same truncating midpoint walk, even on an unsorted list
          lo  = 0;
          hi  = held - 1;
          mid = 0;
          while (lo <= hi && !found) begin
            mid = (lo + hi) / 2;
            if (keys[mid] == key) found = 1'b1;
            else if (keys[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
          if (found) r.position = mid[POS_W-1:0];
          else r.status = ST_ABSENT;
        end
        default: begin
        end
      endcase
      r.total = held[TOTAL_W-1:0];
      if (held > peak_held) peak_held = held;
      status_tally[r.status]++;
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("[%0t] mismatch in %s: got %0d, want %0d (result %0d)",
                 $time, what, got, want, results_seen);
    endtask

    // Compare one accepted result item with the oldest owed result.
    task check_result(logic [OUT_TDATA_W-1:0] word);
      list_result_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected result", word, 0);
      end else begin
        want = owed_q.pop_front();
        if (word[1:0] != want.status)
          report_mismatch("status", word[1:0], want.status);
        if (word[7:2] != want.position)
          report_mismatch("position", word[7:2], want.position);
        if (word[14:8] != want.total)
          report_mismatch("element_total", word[14:8], want.total);
      end
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  list_scoreboard sb = new();
  int             idle_pct = 0;   // share of idling on both sides, set per phase
  int             stall_left = 0;
  int             cycle_count = 0;
  int unsigned    sent = 0;

  array_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check every accepted item, then stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
        stall_left = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Keys: many small values so inserts collide and searches hit, the four
  // corners of the signed range, and fully random patterns.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 16) - 8;
      5, 6: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h8000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h7FFF_FFFE;
          4: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Searches mostly look for a key that is held right now.
  function automatic logic [KEY_W-1:0] pick_search_key();
    if (sb.held > 0 && $urandom_range(0, 9) < 6)
      return sb.keys[$urandom_range(0, sb.held - 1)];
    return pick_key();
  endfunction

  // Present one item; valid stays high into the next item unless a gap is drawn.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] slot);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, slot, key, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, key, slot);
    sent++;
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Empty the list, fill it with sorted inserts, then hit it while full.
  task automatic fill_and_probe();
    send_command(CMD_CLEAR, pick_key(), IDX_W'($urandom_range(0, 127)));
    repeat (CAPACITY) send_command(CMD_INS_SORT, pick_key(), IDX_W'($urandom_range(0, 127)));
    send_command(CMD_INS_AT, pick_key(), 7'd127);   // full and out of range at once
    send_command(CMD_INS_AT, pick_key(), IDX_W'($urandom_range(0, CAPACITY)));
    send_command(CMD_INS_SORT, pick_key(), IDX_W'($urandom_range(0, 127)));
    repeat (8) send_command(CMD_BIN, pick_search_key(), IDX_W'($urandom_range(0, 127)));
    send_command(CMD_LIN, sb.keys[CAPACITY-1], IDX_W'($urandom_range(0, 127)));
  endtask

  // Random phase. Sorted-only phases keep the list ordered so binary search
  // finds what it looks for; mixed phases let insert at index scramble it.
  task automatic run_phase(input int n, input bit sorted_only, input int clear_pct);
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] slot;
    int               roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      slot = IDX_W'($urandom_range(0, 127));
      if (roll < clear_pct || (sb.held == CAPACITY && $urandom_range(0, 19) == 0))
        cmd = CMD_CLEAR;
      else if (roll < clear_pct + 3)
        cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      else if (roll < 52)
        cmd = (sorted_only || $urandom_range(0, 2) != 0) ? CMD_INS_SORT : CMD_INS_AT;
      else if (roll < 76)
        cmd = CMD_LIN;
      else
        cmd = CMD_BIN;
      if (cmd == CMD_LIN || cmd == CMD_BIN) key = pick_search_key();
      else key = pick_key();
      // insert at index mostly lands inside the list, sometimes anywhere
      if (cmd == CMD_INS_AT && $urandom_range(0, 9) < 8)
        slot = IDX_W'($urandom_range(0, sb.held));
      send_command(cmd, key, slot);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, bad indexes, ordered inserts at the key extremes,
    // hits and misses for both searches, unused codes, clear.
    idle_pct = 20;
    send_command(CMD_CLEAR, 32'h0, 7'd0);
    send_command(CMD_LIN, 32'h0, 7'd0);                  // empty list
    send_command(CMD_BIN, 32'h0, 7'd0);
    send_command(CMD_INS_AT, 32'h1, 7'd1);               // index above count
    send_command(CMD_INS_AT, 32'h2, 7'd127);
    send_command(CMD_INS_AT, 32'h7FFF_FFFF, 7'd0);
    send_command(CMD_INS_SORT, 32'h8000_0000, 7'd0);
    send_command(CMD_INS_SORT, 32'h0000_0000, 7'd0);
    send_command(CMD_INS_SORT, 32'hFFFF_FFFF, 7'd0);
    send_command(CMD_INS_AT, 32'h0000_0007, 7'd4);       // append breaks the order
    send_command(CMD_LIN, 32'h0000_0007, 7'd0);
    send_command(CMD_LIN, 32'h7FFF_FFFF, 7'd0);
    send_command(CMD_LIN, 32'h0000_3039, 7'd0);          // absent
    send_command(CMD_BIN, 32'h0000_0000, 7'd0);
    send_command(CMD_BIN, 32'h0000_0007, 7'd0);          // unsorted tail
    send_command(CMD_BIN, 32'h8000_0000, 7'd0);
    send_command(CMD_BIN, 32'h0000_3039, 7'd0);
    send_command(CMD_INS_SORT, 32'h0000_0000, 7'd0);     // duplicate key
    send_command(CMD_INS_AT, 32'h1234_5678, 7'd3);
    send_command(CMD_UNUSED_FIRST, 32'hFFFF_FFFF, 7'd127);
    send_command(CMD_UNUSED_MID, 32'h5555_5555, 7'd42);
    send_command(CMD_UNUSED_LAST, 32'hAAAA_AAAA, 7'd85);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF, 7'd127);
    drain_results();

    fill_and_probe();
    drain_results();

    run_phase(PHASE_ITEMS, 1'b1, 0);
    drain_results();
    idle_pct = 0;                          // back-to-back stretch
    run_phase(PHASE_ITEMS, 1'b0, 2);
    drain_results();
    idle_pct = 45;                         // heavy gaps and stalls
    run_phase(PHASE_ITEMS, 1'b0, 1);
    drain_results();
    idle_pct = 20;
    run_phase(PHASE_ITEMS, 1'b1, 1);
    drain_results();
    idle_pct = 0;                          // closing part runs flat out
    run_phase(PHASE_ITEMS, 1'b0, 2);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d commands over both searches, both inserts, clear and unused codes",
             sent);
    $display("results: %0d ok, %0d full, %0d bad index, %0d not found; peak %0d entries",
             sb.status_tally[ST_OK], sb.status_tally[ST_FULL], sb.status_tally[ST_RANGE],
             sb.status_tally[ST_ABSENT], sb.peak_held);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
